/* hw/rtl/wtd_pkg.sv */
`timescale 1ns / 1ps
// wtd_pkg: widths, candidate tables and handshake structs for the wheel-30 prime tester
// used by wtd_rem_unit, wtd_seq and wheel_trial_division_prime_test; no dependencies

package wtd_pkg;

  // magnitude of the tested word
  localparam int unsigned MAG_W      = 31;
  // trial divisor, stays below 2^16 because d*d never passes 2^30 by more than one step
  localparam int unsigned D_W        = 16;
  // partial remainder, always below the divisor
  localparam int unsigned REM_W      = D_W;
  // low part of the magnitude still to be shifted into the remainder, two bits a step
  localparam int unsigned TAIL_W     = 32;
  localparam int unsigned DIGITS     = TAIL_W / 2;
  localparam int unsigned CNT_W      = $clog2(DIGITS + 1);
  // running square of the wheel candidate
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned GAP_W      = 3;
  localparam int unsigned NUM_SMALL  = 10;

  localparam logic [D_W-1:0]  WHEEL_START    = 16'd31;
  localparam logic [SQ_W-1:0] WHEEL_START_SQ = 32'd961;

  // sequencer to remainder unit
  typedef struct packed {
    logic load;
    logic step;
  } wtd_rem_ctl_t;

  // remainder unit to sequencer
  typedef struct packed {
    logic empty;  // no digit left
    logic last;   // one digit left
    logic zero;   // remainder is zero
  } wtd_rem_sts_t;

  // sequencer to top level
  typedef struct packed {
    logic idle;
    logic done;
    logic prime;
  } wtd_seq_sts_t;

  // primes below the wheel, tested first
  function automatic logic [D_W-1:0] wtd_small_prime(input logic [IDX_W-1:0] idx);
    logic [D_W-1:0] p;
    unique case (idx)
      4'd0:    p = 16'd2;
      4'd1:    p = 16'd3;
      4'd2:    p = 16'd5;
      4'd3:    p = 16'd7;
      4'd4:    p = 16'd11;
      4'd5:    p = 16'd13;
      4'd6:    p = 16'd17;
      4'd7:    p = 16'd19;
      4'd8:    p = 16'd23;
      4'd9:    p = 16'd29;
      default: p = 16'd29;
    endcase
    return p;
  endfunction

  // gaps between wheel candidates, starting from 31
  function automatic logic [GAP_W-1:0] wtd_wheel_gap(input logic [GAP_W-1:0] g);
    logic [GAP_W-1:0] gap;
    unique case (g)
      3'd0:    gap = 3'd6;
      3'd1:    gap = 3'd4;
      3'd2:    gap = 3'd2;
      3'd3:    gap = 3'd4;
      3'd4:    gap = 3'd2;
      3'd5:    gap = 3'd4;
      3'd6:    gap = 3'd6;
      default: gap = 3'd2;
    endcase
    return gap;
  endfunction

  // (d + g)^2 - d^2 = 2*g*d + g*g for the three wheel gaps
  function automatic logic [SQ_W-1:0] wtd_sq_step(input logic [D_W-1:0] d,
                                                   input logic [GAP_W-1:0] gap);
    logic [SQ_W-1:0] dw;
    logic [SQ_W-1:0] inc;
    dw = SQ_W'(d);
    unique case (gap)
      3'd2:    inc = (dw << 2) + 32'd4;
      3'd4:    inc = (dw << 3) + 32'd16;
      3'd6:    inc = (dw << 3) + (dw << 2) + 32'd36;
      default: inc = '0;
    endcase
    return inc;
  endfunction

endpackage

/* hw/rtl/wheel_trial_division_prime_test.sv */
`timescale 1ns / 1ps
// wheel_trial_division_prime_test: top level, magnitude, sequencer, remainder unit, output word
// depends on wtd_pkg, wtd_rem_unit and wtd_seq
//
//   channel  valid       ready       payload     direction
//   in       in_valid_i  in_ready_o  value_i     word in, signed 31-bit integer
//   out      out_valid_o out_ready_i is_prime_o  word out, one per input word
//
// trial order: the ten primes below 31 are tried first, then wheel candidates 31, 37, 41
// and so on while d*d <= |value|; for each trial divisor the radix-4 remainder unit works
// through the base-4 digits of the magnitude below the divisor's prefix, one digit per
// cycle, after the leading digits that keep the prefix below the divisor are stripped for
// good; composites stop early
// reset clears the sequencer state and the output valid; no clearing pass
// in_ready_o is high only while the sequencer is idle; a finished result waits for the
// output register to free up, and the output register holds while out_ready_i is low

module wheel_trial_division_prime_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [wtd_pkg::MAG_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_prime_o
);
  import wtd_pkg::*;

  logic              in_fire;
  logic [MAG_W-1:0]  mag;
  logic              ack;

  wtd_seq_sts_t      seq_sts;
  wtd_rem_ctl_t      rem_ctl;
  wtd_rem_sts_t      rem_sts;
  logic [REM_W-1:0]  rem_load;
  logic [TAIL_W-1:0] tail_load;
  logic [CNT_W-1:0]  cnt_load;
  logic [D_W-1:0]    div_load;

  logic              out_valid_q, out_valid_d;
  logic              is_prime_q, is_prime_d;

  assign in_ready_o = seq_sts.idle;
  assign in_fire    = in_valid_i && in_ready_o;

  // magnitude; the most negative word gives 2^30, which still fits unsigned
  assign mag = value_i[MAG_W-1] ? MAG_W'(-value_i) : MAG_W'(value_i);

  // result moves into the output word once the slot is empty or being taken
  assign ack = seq_sts.done && (!out_valid_q || out_ready_i);

  wtd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .mag_i       (mag),
    .ack_i       (ack),
    .rem_sts_i   (rem_sts),
    .rem_ctl_o   (rem_ctl),
    .rem_load_o  (rem_load),
    .tail_load_o (tail_load),
    .cnt_load_o  (cnt_load),
    .div_load_o  (div_load),
    .sts_o       (seq_sts)
  );

  wtd_rem_unit u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (rem_ctl),
    .load_rem_i  (rem_load),
    .load_tail_i (tail_load),
    .load_cnt_i  (cnt_load),
    .load_div_i  (div_load),
    .sts_o       (rem_sts)
  );

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    if (ack) begin
      out_valid_d = 1'b1;
      is_prime_d  = seq_sts.prime;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

/* hw/rtl/wtd_rem_unit.sv */
`timescale 1ns / 1ps
// wtd_rem_unit: shared radix-4 remainder unit, one base-4 digit of the magnitude per step
// depends on wtd_pkg

module wtd_rem_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wtd_pkg::wtd_rem_ctl_t         ctl_i,
  input  logic [wtd_pkg::REM_W-1:0]     load_rem_i,
  input  logic [wtd_pkg::TAIL_W-1:0]    load_tail_i,
  input  logic [wtd_pkg::CNT_W-1:0]     load_cnt_i,
  input  logic [wtd_pkg::D_W-1:0]       load_div_i,
  output wtd_pkg::wtd_rem_sts_t         sts_o
);
  import wtd_pkg::*;

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [TAIL_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [D_W-1:0]    div_q, div_d;
  logic [REM_W+1:0]  div3_q, div3_d;

  logic [REM_W+1:0]  x;
  logic [REM_W+1:0]  div1;
  logic [REM_W+1:0]  div2;
  logic [REM_W-1:0]  rem_red;

  // shifted remainder stays below 4*d, so at most 3*d comes off
  assign x    = {rem_q, tail_q[TAIL_W-1 -: 2]};
  assign div1 = {2'b00, div_q};
  assign div2 = {1'b0, div_q, 1'b0};

  always_comb begin
    priority if (x >= div3_q) begin
      rem_red = REM_W'(x - div3_q);
    end else if (x >= div2) begin
      rem_red = REM_W'(x - div2);
    end else if (x >= div1) begin
      rem_red = REM_W'(x - div1);
    end else begin
      rem_red = REM_W'(x);
    end
  end

  always_comb begin
    rem_d  = rem_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    div3_d = div3_q;
    if (ctl_i.load) begin
      rem_d  = load_rem_i;
      tail_d = load_tail_i;
      cnt_d  = load_cnt_i;
      div_d  = load_div_i;
      div3_d = {2'b00, load_div_i} + {1'b0, load_div_i, 1'b0};
    end else if (ctl_i.step) begin
      rem_d  = rem_red;
      tail_d = tail_q << 2;
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    tail_q <= tail_d;
    div_q  <= div_d;
    div3_q <= div3_d;
  end

  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.last  = (cnt_q == CNT_W'(1));
  assign sts_o.zero  = (rem_q == '0);

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctl_i.step) |-> (rem_q < div_q))
    else $error("remainder not reduced below divisor");

  a_no_step_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step |-> (cnt_q != '0))
    else $error("step issued with no digit left");

  a_load_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.load && ctl_i.step))
    else $error("load and step in the same cycle");
`endif

endmodule

/* hw/rtl/wtd_seq.sv */
`timescale 1ns / 1ps
// wtd_seq: candidate sequencer, walks small primes then the wheel and drives the remainder unit
// depends on wtd_pkg

module wtd_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wtd_pkg::MAG_W-1:0]     mag_i,
  input  logic                          ack_i,
  input  wtd_pkg::wtd_rem_sts_t         rem_sts_i,
  output wtd_pkg::wtd_rem_ctl_t         rem_ctl_o,
  output logic [wtd_pkg::REM_W-1:0]     rem_load_o,
  output logic [wtd_pkg::TAIL_W-1:0]    tail_load_o,
  output logic [wtd_pkg::CNT_W-1:0]     cnt_load_o,
  output logic [wtd_pkg::D_W-1:0]       div_load_o,
  output wtd_pkg::wtd_seq_sts_t         sts_o
);
  import wtd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TEST = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_NEXT = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [D_W-1:0]    div_q, div_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic              small_q, small_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  ndig_q, ndig_d;
  logic [REM_W-1:0]  pre_q, pre_d;
  logic [TAIL_W-1:0] tail_q, tail_d;
  logic              prime_q, prime_d;

  logic [REM_W+1:0]  pre_ext;
  logic [GAP_W-1:0]  gap;

  // prefix with one more digit pulled in
  assign pre_ext = {pre_q, tail_q[TAIL_W-1 -: 2]};
  assign gap     = wtd_wheel_gap(idx_q[GAP_W-1:0]);

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    div_d     = div_q;
    sq_d      = sq_q;
    small_d   = small_q;
    idx_d     = idx_q;
    ndig_d    = ndig_q;
    pre_d     = pre_q;
    tail_d    = tail_q;
    prime_d   = prime_q;
    rem_ctl_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mag_d   = mag_i;
          div_d   = wtd_small_prime('0);
          sq_d    = '0;
          small_d = 1'b1;
          idx_d   = '0;
          ndig_d  = CNT_W'(DIGITS);
          pre_d   = '0;
          tail_d  = TAIL_W'(mag_i);
          state_d = ST_TEST;
        end
      end

      ST_TEST: begin
        priority if (mag_q < MAG_W'(2)) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (small_q && (mag_q == MAG_W'(div_q))) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else if (!small_q && (sq_q > SQ_W'(mag_q))) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else if ((ndig_q != '0) && (pre_ext < {2'b00, div_q})) begin
          // prefix still below divisor, skip one leading digit for good
          pre_d  = REM_W'(pre_ext);
          tail_d = tail_q << 2;
          ndig_d = ndig_q - CNT_W'(1);
        end else begin
          rem_ctl_o.load = 1'b1;
          state_d        = ST_DIV;
        end
      end

      ST_DIV: begin
        if (rem_sts_i.empty) begin
          state_d = ST_NEXT;
        end else begin
          rem_ctl_o.step = 1'b1;
          if (rem_sts_i.last) begin
            state_d = ST_NEXT;
          end
        end
      end

      ST_NEXT: begin
        if (rem_sts_i.zero) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_TEST;
          if (small_q) begin
            if (idx_q == IDX_W'(NUM_SMALL - 1)) begin
              div_d   = WHEEL_START;
              sq_d    = WHEEL_START_SQ;
              small_d = 1'b0;
              idx_d   = '0;
            end else begin
              div_d = wtd_small_prime(idx_q + IDX_W'(1));
              idx_d = idx_q + IDX_W'(1);
            end
          end else begin
            div_d = div_q + D_W'(gap);
            sq_d  = sq_q + wtd_sq_step(div_q, gap);
            idx_d = {1'b0, idx_q[GAP_W-1:0] + GAP_W'(1)};
          end
        end
      end

      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    small_q <= small_d;
    idx_q   <= idx_d;
    ndig_q  <= ndig_d;
    pre_q   <= pre_d;
    tail_q  <= tail_d;
    prime_q <= prime_d;
  end

  assign rem_load_o  = pre_q;
  assign tail_load_o = tail_q;
  assign cnt_load_o  = ndig_q;
  assign div_load_o  = div_q;

  assign sts_o.idle  = (state_q == ST_IDLE);
  assign sts_o.done  = (state_q == ST_DONE);
  assign sts_o.prime = prime_q;

`ifndef ASSERT_OFF
  a_prefix_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_ctl_o.load |-> (pre_q < div_q))
    else $error("remainder loaded with prefix not below divisor");

  a_square_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TEST) && !small_q) |-> (sq_q == (SQ_W'(div_q) * SQ_W'(div_q))))
    else $error("running square out of step with candidate");

  a_div_rising: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_NEXT) && !rem_sts_i.zero) |=> (div_q > $past(div_q)))
    else $error("candidate did not advance");
`endif

endmodule
